[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, checked out of reset.
`define AST_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property violated");

// Condition that must never be seen out of reset.
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

`else

`define AST_PROP(label, clk, rst_n, prop)
`define AST_NEVER(label, clk, rst_n, expr)

`endif

`endif

[rtl/adtd_pkg.sv]
package adtd_pkg;

	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned DIST_TBL_W = 7;
	localparam int unsigned DIST_FRM_W = 8;
	localparam int unsigned SEG_W      = 4;
	localparam int unsigned DELTA_W    = 10;
	localparam int unsigned DEC_W      = 3;

	// Segment codes: 1..12 interpolate inside the table
	localparam logic [SEG_W-1:0] SEG_NEAR = 4'd0;
	localparam logic [SEG_W-1:0] SEG_FAR  = 4'd13;
	localparam int unsigned      SEG_LAST = 12;
	localparam int unsigned      DEC_MAX  = 5;

	localparam int unsigned NEAR_CM = 10;
	localparam int unsigned FAR_CM  = 70;
	localparam int unsigned STEP_CM = 5;

	// descending sensor curve, one point every 5 cm from 10 to 70 cm
	localparam logic [SAMPLE_W-1:0] LIN_POINTS [0:12] = '{
		12'd3090, 12'd2129, 12'd1630, 12'd1340, 12'd1177, 12'd1032, 12'd907,
		12'd835,  12'd794,  12'd740,  12'd716,  12'd670,  12'd620
	};

	// one fifth of each segment span, indexed by segment code
	localparam logic [7:0] SEG_DIVS [0:13] = '{
		8'd0,  8'd192, 8'd99, 8'd58, 8'd32, 8'd29, 8'd25,
		8'd14, 8'd8,   8'd10, 8'd4,  8'd9,  8'd10, 8'd0
	};

	// reciprocal formula, Q16
	localparam int unsigned   QUO_W         = 32;
	localparam logic [31:0]   Q16_NUMERATOR = 32'd3060308312;
	localparam logic [32:0]   Q16_OFFSET    = 33'd544522;
	localparam int unsigned   DIV_BITS      = 4;
	localparam int unsigned   DIV_STAGES    = QUO_W / DIV_BITS;

	typedef struct packed {
		logic s2;
		logic s3;
	} tbl_en_t;

endpackage

[rtl/adtd_div_stage.sv]
module adtd_div_stage (
	input  logic                                clk,
	input  logic                                en,
	input  logic [adtd_pkg::SAMPLE_W-1:0]       divisor,
	input  logic [adtd_pkg::SAMPLE_W-1:0]       rem_prev,
	input  logic [adtd_pkg::QUO_W-1:0]          quo_prev,
	input  logic [adtd_pkg::DIV_BITS-1:0]       num_bits,
	output logic [adtd_pkg::SAMPLE_W-1:0]       divisor_next,
	output logic [adtd_pkg::SAMPLE_W-1:0]       rem_next,
	output logic [adtd_pkg::QUO_W-1:0]          quo_next
);

	logic [adtd_pkg::SAMPLE_W-1:0] rem_c;
	logic [adtd_pkg::QUO_W-1:0]    quo_c;

	// restoring long division, DIV_BITS quotient bits per stage
	always_comb begin
		logic [adtd_pkg::SAMPLE_W:0] trial;
		rem_c = rem_prev;
		quo_c = quo_prev;
		trial = '0;
		for (int i = 0; i < adtd_pkg::DIV_BITS; i++) begin
			trial = {rem_c, num_bits[adtd_pkg::DIV_BITS-1-i]};
			if (trial >= {1'b0, divisor}) begin
				rem_c = adtd_pkg::SAMPLE_W'(trial - {1'b0, divisor});
				quo_c = {quo_c[adtd_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_c = trial[adtd_pkg::SAMPLE_W-1:0];
				quo_c = {quo_c[adtd_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			divisor_next <= divisor;
			rem_next     <= rem_c;
			quo_next     <= quo_c;
		end
	end

endmodule

[rtl/adtd_table.sv]
module adtd_table (
	input  logic                                 clk,
	input  adtd_pkg::tbl_en_t                    en,
	input  logic [adtd_pkg::SAMPLE_W-1:0]        sample,
	output logic [adtd_pkg::DIST_TBL_W-1:0]      dist_cm
);

	logic [adtd_pkg::SEG_W-1:0]      seg_c;
	logic [adtd_pkg::DELTA_W-1:0]    delta_c;
	logic [adtd_pkg::SEG_W-1:0]      seg_s2;
	logic [adtd_pkg::DELTA_W-1:0]    delta_s2;
	logic [adtd_pkg::DEC_W-1:0]      dec_c;
	logic [adtd_pkg::DIST_TBL_W-1:0] dist_c;
	logic [adtd_pkg::DIST_TBL_W-1:0] dist_s3;

	// segment search: lowest index whose point is at or below the sample
	always_comb begin
		seg_c   = adtd_pkg::SEG_NEAR;
		delta_c = '0;
		for (int k = adtd_pkg::SEG_LAST; k >= 1; k--) begin
			if (sample >= adtd_pkg::LIN_POINTS[k]) begin
				seg_c   = adtd_pkg::SEG_W'(k);
				delta_c = adtd_pkg::DELTA_W'(sample - adtd_pkg::LIN_POINTS[k]);
			end
		end
		if (sample >= adtd_pkg::LIN_POINTS[0])
			seg_c = adtd_pkg::SEG_NEAR;
		if (sample <= adtd_pkg::LIN_POINTS[adtd_pkg::SEG_LAST])
			seg_c = adtd_pkg::SEG_FAR;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2   <= seg_c;
			delta_s2 <= delta_c;
		end
	end

	// quotient is at most 5: count thresholds passed
	always_comb begin
		dec_c = '0;
		for (int j = 1; j <= adtd_pkg::DEC_MAX; j++) begin
			if ({1'b0, delta_s2} >=
			    11'(j * int'(adtd_pkg::SEG_DIVS[seg_s2])))
				dec_c = dec_c + 3'd1;
		end
		case (seg_s2)
			adtd_pkg::SEG_NEAR: dist_c = adtd_pkg::DIST_TBL_W'(adtd_pkg::NEAR_CM);
			adtd_pkg::SEG_FAR:  dist_c = adtd_pkg::DIST_TBL_W'(adtd_pkg::FAR_CM);
			default: dist_c = adtd_pkg::DIST_TBL_W'(adtd_pkg::NEAR_CM +
			                  adtd_pkg::STEP_CM * 32'(seg_s2)) -
			                  adtd_pkg::DIST_TBL_W'(dec_c);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s3)
			dist_s3 <= dist_c;
	end

	assign dist_cm = dist_s3;

endmodule

[rtl/adc_to_distance_linearizer.sv]
// IR distance sensor linearizer.
// Input channel: adc_sample with sample_valid / sample_stall. One transaction
// per cycle is taken when sample_valid is high and sample_stall is low.
// Output channel: distance_by_table and distance_by_formula with dist_valid /
// dist_stall; a transaction completes when dist_valid is high and dist_stall low.
// Pipeline: ten register stages. s1 holds the sample, s2..s9 are the eight
// stages of the reciprocal divider (4 quotient bits each), s10 is the output
// register with the offset subtract and saturation. The table path finishes
// in s3 and rides along to s10.
// Path: s1 takes the input transaction, s2..s9 divide and s10 registers the
// result. Throughput: one transaction per cycle while dist_stall is low, set by
// the pipelined divider rather than by any loop.
// Stall: each stage advances when empty or when the next stage advances, so
// bubbles close up behind a stalled output; sample_stall rises only once all
// ten stages hold results. Nothing is dropped or repeated.
// Reset (arst_n low): all valid bits clear at once; payload registers are not reset.
`include "assert_macros.svh"

module adc_to_distance_linearizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic [adtd_pkg::SAMPLE_W-1:0]         adc_sample,
	output logic                                  dist_valid,
	input  logic                                  dist_stall,
	output logic [adtd_pkg::DIST_TBL_W-1:0]       distance_by_table,
	output logic [adtd_pkg::DIST_FRM_W-1:0]       distance_by_formula
);

	localparam int unsigned LAST = 10;

	// handshake chain
	logic vld_s [1:LAST];
	logic vin   [1:LAST];
	logic rdy   [1:LAST+1];
	logic en    [1:LAST];

	// payload
	logic [adtd_pkg::SAMPLE_W-1:0]   sample_s1;
	logic [adtd_pkg::SAMPLE_W-1:0]   div_s  [1:9];
	logic [adtd_pkg::SAMPLE_W-1:0]   rem_s  [1:9];
	logic [adtd_pkg::QUO_W-1:0]      quo_s  [1:9];
	logic                            zero_s [2:9];
	logic [adtd_pkg::DIST_TBL_W-1:0] tbl_dist_s3;
	logic [adtd_pkg::DIST_TBL_W-1:0] tbl_s  [4:LAST];
	logic [adtd_pkg::DIST_FRM_W-1:0] frm_c;
	logic [adtd_pkg::DIST_FRM_W-1:0] frm_s10;
	logic [adtd_pkg::QUO_W:0]        diff_c;
	adtd_pkg::tbl_en_t               tbl_en;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		rdy[LAST+1] = !dist_stall;
		for (int k = LAST; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
		vin[1] = sample_valid;
		for (int k = 2; k <= LAST; k++)
			vin[k] = vld_s[k-1];
		for (int k = 1; k <= LAST; k++)
			en[k] = rdy[k] && vin[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++)
				vld_s[k] <= 1'b0;
		end else begin
			for (int k = 1; k <= LAST; k++)
				if (rdy[k])
					vld_s[k] <= vin[k];
		end
	end

	assign sample_stall = !rdy[1];
	assign dist_valid   = vld_s[LAST];

	always_ff @(posedge clk) begin
		if (en[1])
			sample_s1 <= adc_sample;
	end

	// table interpolation, s1 -> s3
	assign tbl_en.s2 = en[2];
	assign tbl_en.s3 = en[3];

	adtd_table u_table (
		.clk     (clk),
		.en      (tbl_en),
		.sample  (sample_s1),
		.dist_cm (tbl_dist_s3)
	);

	// reciprocal divider, s1 -> s9
	assign div_s[1] = sample_s1;
	assign rem_s[1] = '0;
	assign quo_s[1] = '0;

	for (genvar j = 0; j < adtd_pkg::DIV_STAGES; j++) begin : g_div
		adtd_div_stage u_stage (
			.clk          (clk),
			.en           (en[j+2]),
			.divisor      (div_s[j+1]),
			.rem_prev     (rem_s[j+1]),
			.quo_prev     (quo_s[j+1]),
			.num_bits     (adtd_pkg::Q16_NUMERATOR[adtd_pkg::QUO_W-1-adtd_pkg::DIV_BITS*j -:
			               adtd_pkg::DIV_BITS]),
			.divisor_next (div_s[j+2]),
			.rem_next     (rem_s[j+2]),
			.quo_next     (quo_s[j+2])
		);
	end

	// side payload: zero flag and table result ride along
	always_ff @(posedge clk) begin
		if (en[2])
			zero_s[2] <= (sample_s1 == '0);
		for (int k = 3; k <= 9; k++)
			if (en[k])
				zero_s[k] <= zero_s[k-1];
		if (en[4])
			tbl_s[4] <= tbl_dist_s3;
		for (int k = 5; k <= LAST; k++)
			if (en[k])
				tbl_s[k] <= tbl_s[k-1];
	end

	// offset subtract, floor by 2^16, clamp to 0..255; a zero sample gives 255
	always_comb begin
		diff_c = {1'b0, quo_s[9]} - adtd_pkg::Q16_OFFSET;
		if (zero_s[9])
			frm_c = '1;
		else if (diff_c[adtd_pkg::QUO_W])
			frm_c = '0;
		else if (|diff_c[adtd_pkg::QUO_W-1:24])
			frm_c = '1;
		else
			frm_c = diff_c[23:16];
	end

	always_ff @(posedge clk) begin
		if (en[LAST])
			frm_s10 <= frm_c;
	end

	assign distance_by_table   = tbl_s[LAST];
	assign distance_by_formula = frm_s10;

	// the input backs up only when the first stage is occupied
	`AST_PROP(a_stall_needs_full_s1, clk, arst_n, sample_stall |-> vld_s[1])
	// table result always within 10..70 cm
	`AST_PROP(a_table_range, clk, arst_n,
		dist_valid |-> (distance_by_table >= 7'd10 && distance_by_table <= 7'd70))
	// a zero sample leaves the divider as a saturated distance
	`AST_PROP(a_zero_saturates, clk, arst_n,
		(en[LAST] && zero_s[9]) |=> (distance_by_formula == 8'd255))

endmodule
